// ===== rtl/smsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsr_pkg
// Shared constants and types for the shuffled minimal standard generator.
// ----------------------------------------------------------------------------
package smsr_pkg;

  localparam int VALUE_W = 31;

  localparam logic [14:0]        LEHMER_MUL = 15'd16807;
  localparam logic [VALUE_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;

  // warm-up steps run ahead of the table fill
  localparam int WARMUP_STEPS = 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_IDX,
    S_INIT_MUL,
    S_INIT_FOLD,
    S_INIT_IDX,
    S_DRAW,
    S_WAIT
  } state_t;

endpackage

// ===== rtl/smsr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module smsr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/smsr_lehmer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsr_lehmer
// Lehmer step x * 16807 mod (2^31 - 1): registered product, then a
// Mersenne fold with one conditional subtract.
// ----------------------------------------------------------------------------
module smsr_lehmer (
  input  logic                        clk,
  input  logic [smsr_pkg::VALUE_W-1:0] x,
  output logic [smsr_pkg::VALUE_W-1:0] x_next
);

  localparam int PW = smsr_pkg::VALUE_W + 15;

  logic [PW-1:0] prod;
  logic [31:0]   sum;

  always_ff @(posedge clk) begin
    prod <= PW'(x) * PW'(smsr_pkg::LEHMER_MUL);
  end

  always_comb begin
    sum = 32'(prod[smsr_pkg::VALUE_W-1:0]) + 32'(prod[PW-1:smsr_pkg::VALUE_W]);
    if (sum >= 32'(smsr_pkg::LEHMER_MOD)) begin
      x_next = smsr_pkg::VALUE_W'(sum - 32'(smsr_pkg::LEHMER_MOD));
    end else begin
      x_next = sum[smsr_pkg::VALUE_W-1:0];
    end
  end

endmodule

// ===== rtl/smsr_index.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsr_index
// Table index from the shuffle output: divide by a constant through a
// registered reciprocal product, one-step correction and clamp.
// ----------------------------------------------------------------------------
module smsr_index #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                                clk,
  input  logic [smsr_pkg::VALUE_W-1:0]        value,
  output logic [$clog2(TABLE_ENTRIES)-1:0]    idx
);

  localparam longint DIVISOR = 1 + 2147483646 / TABLE_ENTRIES;
  localparam int     SHIFT   = 40;
  localparam longint RECIP   = (64'd1 << SHIFT) / DIVISOR;
  localparam int     RW      = $clog2(RECIP + 1);
  localparam int     PW      = smsr_pkg::VALUE_W + RW;
  localparam int     QW      = $clog2(TABLE_ENTRIES) + 2;
  localparam int     AW      = $clog2(TABLE_ENTRIES);

  logic [PW-1:0]                 prod;
  logic [smsr_pkg::VALUE_W-1:0]  value_q;
  logic [QW-1:0]                 q_est;
  logic [QW-1:0]                 q;
  logic [31:0]                   qd;
  logic [31:0]                   rem;

  always_ff @(posedge clk) begin
    prod    <= PW'(value) * PW'(RECIP);
    value_q <= value;
  end

  // estimate is exact or one low
  always_comb begin
    q_est = QW'(prod >> SHIFT);
    qd    = 32'(q_est) * 32'(DIVISOR);
    rem   = 32'(value_q) - qd;
    q     = (rem >= 32'(DIVISOR)) ? q_est + QW'(1) : q_est;
    if (q >= QW'(TABLE_ENTRIES)) begin
      idx = AW'(TABLE_ENTRIES - 1);
    end else begin
      idx = q[AW-1:0];
    end
  end

endmodule

// ===== rtl/shuffled_minimal_standard_rng.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shuffled_minimal_standard_rng
// Lehmer generator (16807 mod 2^31-1) behind a Bays-Durham shuffle table.
//
//   channel  handshake              payload
//   cfg      cfg_valid / cfg_ready  seed
//   in       in_valid / in_stall    restart
//   out      out_valid / out_stall  value
//
// A draw reads the table alongside the Lehmer product, then does write-back
// and result; the next index comes out of the divide stage in S_IDX after
// the result load and is used by a transaction accepted there, else held.
// Initialization (first transaction after reset, or restart) runs the
// warm-up and table-fill steps on the serial Lehmer unit, then S_INIT_IDX.
// Reset is synchronous; the table needs no clearing pass.
// A stalled output holds the result; one more transaction can be taken
// meanwhile and, after its table write-back, waits for the output register.
// ----------------------------------------------------------------------------
module shuffled_minimal_standard_rng #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [smsr_pkg::VALUE_W-1:0] seed,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        restart,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [smsr_pkg::VALUE_W-1:0] value
);

  localparam int VW        = smsr_pkg::VALUE_W;
  localparam int AW        = $clog2(TABLE_ENTRIES);
  localparam int INIT_LAST = TABLE_ENTRIES + smsr_pkg::WARMUP_STEPS - 1;
  localparam int PSW       = $clog2(INIT_LAST + 1);

  smsr_pkg::state_t state, state_next;

  logic [VW-1:0]  seed_q;
  logic [VW-1:0]  seed_fix;
  logic [VW-1:0]  gen, gen_next;
  logic [VW-1:0]  sout, sout_next;
  logic [PSW-1:0] pos, pos_next;
  logic [AW-1:0]  idx, idx_next;
  logic [AW-1:0]  idx_calc;
  logic [VW-1:0]  lehm_next;
  logic           out_load;
  logic           out_free;
  logic           in_accept;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [VW-1:0]  ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [VW-1:0]  ram_rdata;

  smsr_ram #(
    .WIDTH(VW),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  smsr_lehmer u_lehmer (
    .clk   (clk),
    .x     (gen),
    .x_next(lehm_next)
  );

  smsr_index #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_index (
    .clk  (clk),
    .value(sout_next),
    .idx  (idx_calc)
  );

  assign cfg_ready = 1'b1;
  assign seed_fix  = (seed_q == '0 || seed_q == smsr_pkg::LEHMER_MOD) ? VW'(1) : seed_q;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = rst || !(state == smsr_pkg::S_IDLE || state == smsr_pkg::S_IDX);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smsr_pkg::S_IDLE;
      seed_q    <= VW'(1);
      gen       <= '0;
      sout      <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      gen   <= gen_next;
      sout  <= sout_next;
      pos   <= pos_next;
      if (cfg_valid && cfg_ready) begin
        seed_q <= seed;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (out_load) begin
      value <= sout_next;
    end
  end

  always_comb begin
    state_next = state;
    gen_next   = gen;
    sout_next  = sout;
    pos_next   = pos;
    idx_next   = idx;
    out_load   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = lehm_next;
    ram_re     = 1'b0;
    ram_raddr  = idx;
    case (state)
      smsr_pkg::S_IDLE, smsr_pkg::S_IDX: begin
        if (state == smsr_pkg::S_IDX) begin
          idx_next  = idx_calc;
          ram_raddr = idx_calc;
        end
        state_next = smsr_pkg::S_IDLE;
        if (in_accept) begin
          if (restart || sout == '0) begin
            gen_next   = seed_fix;
            pos_next   = PSW'(INIT_LAST);
            state_next = smsr_pkg::S_INIT_MUL;
          end else begin
            ram_re     = 1'b1;
            state_next = smsr_pkg::S_DRAW;
          end
        end
      end
      smsr_pkg::S_INIT_MUL: begin
        state_next = smsr_pkg::S_INIT_FOLD;
      end
      smsr_pkg::S_INIT_FOLD: begin
        gen_next = lehm_next;
        if (pos < PSW'(TABLE_ENTRIES)) begin
          ram_we    = 1'b1;
          ram_waddr = pos[AW-1:0];
        end
        if (pos == '0) begin
          sout_next  = lehm_next;
          state_next = smsr_pkg::S_INIT_IDX;
        end else begin
          pos_next   = pos - PSW'(1);
          state_next = smsr_pkg::S_INIT_MUL;
        end
      end
      smsr_pkg::S_INIT_IDX: begin
        idx_next   = idx_calc;
        ram_raddr  = idx_calc;
        ram_re     = 1'b1;
        state_next = smsr_pkg::S_DRAW;
      end
      smsr_pkg::S_DRAW: begin
        gen_next  = lehm_next;
        ram_we    = 1'b1;
        sout_next = ram_rdata;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = smsr_pkg::S_IDX;
        end else begin
          state_next = smsr_pkg::S_WAIT;
        end
      end
      smsr_pkg::S_WAIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = smsr_pkg::S_IDX;
        end
      end
      default: begin
        state_next = smsr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/smsr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsr_checker
// Port-level checks for the shuffled minimal standard generator.
// ----------------------------------------------------------------------------
module smsr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [smsr_pkg::VALUE_W-1:0] value
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value))
    else $error("stalled result changed");

  // deviate never zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> value != '0)
    else $error("zero deviate");

  // deviate never equals the modulus
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> value != smsr_pkg::LEHMER_MOD)
    else $error("deviate equals modulus");

  // one transaction in flight at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

endmodule

bind shuffled_minimal_standard_rng smsr_checker u_smsr_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .value    (value)
);
